>>> hdl/microsecond_tick_to_calendar_macros.svh
// Assertion macros used by the checker file.
`ifndef MICROSECOND_TICK_TO_CALENDAR_MACROS_SVH
`define MICROSECOND_TICK_TO_CALENDAR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mtc_pkg.sv
package mtc_pkg;

    localparam int TickWidth    = 64;
    localparam int DivisorWidth = 18;
    localparam int StepWidth    = 4;
    localparam int DigitWidth   = 8;
    localparam int PartialWidth = 26;
    localparam int RecipWidth   = 27;
    localparam int ProductWidth = 53;
    localparam int YearWidth    = 19;
    localparam int EraDayWidth  = 18;
    localparam int EraWidth     = 10;

    localparam logic [DivisorWidth-1:0] US_PER_MS     = 18'd1000;
    localparam logic [DivisorWidth-1:0] MS_PER_S      = 18'd1000;
    localparam logic [DivisorWidth-1:0] S_PER_MIN     = 18'd60;
    localparam logic [DivisorWidth-1:0] MIN_PER_H     = 18'd60;
    localparam logic [DivisorWidth-1:0] H_PER_DAY     = 18'd24;
    localparam logic [DivisorWidth-1:0] DAYS_PER_WEEK = 18'd7;
    localparam logic [DivisorWidth-1:0] DAYS_PER_ERA  = 18'd146097;

    // Each reciprocal is the ceiling of 2^s / d with s = 26 + ceil(log2 d), which gives the
    // exact quotient for every partial remainder below 2^26.
    localparam int RECIP_SHIFT_1000 = 36;
    localparam int RECIP_SHIFT_60   = 32;
    localparam int RECIP_SHIFT_24   = 31;
    localparam int RECIP_SHIFT_7    = 29;
    localparam int RECIP_SHIFT_ERA  = 44;

    localparam logic [RecipWidth-1:0] RECIP_1000 = RecipWidth'(
        ((64'd1 << RECIP_SHIFT_1000) + 64'(US_PER_MS) - 64'd1) / 64'(US_PER_MS));
    localparam logic [RecipWidth-1:0] RECIP_60 = RecipWidth'(
        ((64'd1 << RECIP_SHIFT_60) + 64'(S_PER_MIN) - 64'd1) / 64'(S_PER_MIN));
    localparam logic [RecipWidth-1:0] RECIP_24 = RecipWidth'(
        ((64'd1 << RECIP_SHIFT_24) + 64'(H_PER_DAY) - 64'd1) / 64'(H_PER_DAY));
    localparam logic [RecipWidth-1:0] RECIP_7 = RecipWidth'(
        ((64'd1 << RECIP_SHIFT_7) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));
    localparam logic [RecipWidth-1:0] RECIP_ERA = RecipWidth'(
        ((64'd1 << RECIP_SHIFT_ERA) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));

    localparam logic [YearWidth-1:0] EPOCH_YEAR    = 19'd1970;
    localparam logic [8:0]           YEARS_PER_ERA = 9'd400;
    localparam logic [8:0]           EPOCH_MOD_400 = 9'd370;
    localparam logic [6:0]           EPOCH_MOD_100 = 7'd70;
    localparam logic [63:0]          EPOCH_WEEKDAY = 64'd4;
    localparam logic [8:0]           DAYS_LEAP     = 9'd366;
    localparam logic [8:0]           DAYS_COMMON   = 9'd365;
    localparam logic [3:0]           LAST_MONTH    = 4'd11;

    typedef enum logic [2:0] {
        DIV_US, DIV_MS, DIV_SEC, DIV_MIN, DIV_HOUR, DIV_WDAY, DIV_ERA
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_YEAR_BASE, ST_CAL_START, ST_CAL_WAIT, ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        CAL_IDLE, CAL_YEAR, CAL_MONTH
    } cal_phase_t;

    typedef struct packed {
        logic                    start;
        logic [TickWidth-1:0]    dividend;
        div_sel_t                sel;
        logic [StepWidth-1:0]    steps;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [TickWidth-1:0]    quotient;
        logic [DivisorWidth-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [YearWidth-1:0]   year;
        logic [EraDayWidth-1:0] days;
    } cal_req_t;

    typedef struct packed {
        logic                 done;
        logic [YearWidth-1:0] year;
        logic [3:0]           month;
        logic [4:0]           day;
    } cal_rsp_t;

    function automatic logic [DivisorWidth-1:0] div_divisor(input div_sel_t sel);
        case (sel)
            DIV_US:   return US_PER_MS;
            DIV_MS:   return MS_PER_S;
            DIV_SEC:  return S_PER_MIN;
            DIV_MIN:  return MIN_PER_H;
            DIV_HOUR: return H_PER_DAY;
            DIV_WDAY: return DAYS_PER_WEEK;
            DIV_ERA:  return DAYS_PER_ERA;
            default:  return US_PER_MS;
        endcase
    endfunction

    function automatic logic [RecipWidth-1:0] div_recip(input div_sel_t sel);
        case (sel)
            DIV_US, DIV_MS:   return RECIP_1000;
            DIV_SEC, DIV_MIN: return RECIP_60;
            DIV_HOUR:         return RECIP_24;
            DIV_WDAY:         return RECIP_7;
            DIV_ERA:          return RECIP_ERA;
            default:          return RECIP_1000;
        endcase
    endfunction

    function automatic logic [DigitWidth-1:0] div_digit(input logic [ProductWidth-1:0] prod,
                                                        input div_sel_t sel);
        case (sel)
            DIV_US, DIV_MS:   return prod[RECIP_SHIFT_1000 +: DigitWidth];
            DIV_SEC, DIV_MIN: return prod[RECIP_SHIFT_60 +: DigitWidth];
            DIV_HOUR:         return prod[RECIP_SHIFT_24 +: DigitWidth];
            DIV_WDAY:         return prod[RECIP_SHIFT_7 +: DigitWidth];
            DIV_ERA:          return prod[RECIP_SHIFT_ERA +: DigitWidth];
            default:          return prod[RECIP_SHIFT_1000 +: DigitWidth];
        endcase
    endfunction

    // Number of dividend bytes in each division.
    function automatic logic [StepWidth-1:0] div_steps(input div_sel_t sel);
        case (sel)
            DIV_US:   return 4'd8;
            DIV_MS:   return 4'd7;
            DIV_SEC:  return 4'd6;
            DIV_MIN:  return 4'd5;
            DIV_HOUR: return 4'd4;
            DIV_WDAY: return 4'd4;
            DIV_ERA:  return 4'd4;
            default:  return 4'd8;
        endcase
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon_idx, input logic leap);
        case (mon_idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: return 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   return 5'd30;
            4'd1:                                      return leap ? 5'd29 : 5'd28;
            default:                                   return 5'd31;
        endcase
    endfunction

endpackage

>>> hdl/mtc_divider.sv
module mtc_divider
    import mtc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    fold_reg, fold_next;
    logic                    done_reg, done_next;
    logic [StepWidth-1:0]    cnt_reg, cnt_next;
    logic [TickWidth-1:0]    q_reg, q_next;
    logic [DivisorWidth-1:0] r_reg, r_next;
    div_sel_t                sel_reg, sel_next;
    logic [DigitWidth-1:0]   qd_reg, qd_next;

    logic [PartialWidth-1:0] part;
    logic [ProductWidth-1:0] prod;
    logic [PartialWidth-1:0] back;
    logic [PartialWidth-1:0] rem;
    logic [6:0]              align;

    // For each dividend byte, the quotient byte is first taken from a reciprocal product
    // and registered, then the partial remainder is formed from it.
    assign part  = {r_reg, q_reg[TickWidth-1 -: DigitWidth]};
    assign prod  = ProductWidth'(part) * ProductWidth'(div_recip(sel_reg));
    assign back  = PartialWidth'(qd_reg) * PartialWidth'(div_divisor(sel_reg));
    assign rem   = part - back;
    assign align = 7'd64 - {req.steps, 3'b000};

    always_comb begin
        busy_next = busy_reg;
        fold_next = fold_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        sel_next  = sel_reg;
        qd_next   = qd_reg;
        if (req.start) begin
            q_next    = req.dividend << align;
            r_next    = '0;
            sel_next  = req.sel;
            cnt_next  = req.steps;
            fold_next = 1'b0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!fold_reg) begin
                qd_next   = div_digit(prod, sel_reg);
                fold_next = 1'b1;
            end else begin
                q_next    = {q_reg[TickWidth-DigitWidth-1:0], qd_reg};
                r_next    = rem[DivisorWidth-1:0];
                cnt_next  = cnt_reg - 4'd1;
                fold_next = 1'b0;
                if (cnt_reg == 4'd1) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fold_reg <= fold_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        sel_reg <= sel_next;
        qd_reg  <= qd_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

>>> hdl/mtc_calendar.sv
module mtc_calendar
    import mtc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cal_req_t req,
    output cal_rsp_t rsp
);

    cal_phase_t             phase_reg, phase_next;
    logic                   done_reg, done_next;
    logic [YearWidth-1:0]   year_reg, year_next;
    logic [EraDayWidth-1:0] day_reg, day_next;
    logic [6:0]             c100_reg, c100_next;
    logic [8:0]             c400_reg, c400_next;
    logic [3:0]             mon_reg, mon_next;

    logic                   leap;
    logic [8:0]             year_len;
    logic [4:0]             mon_len;

    // The counters track the year modulo 100 and modulo 400.
    assign leap     = (year_reg[1:0] == 2'b00 && c100_reg != 7'd0) || c400_reg == 9'd0;
    assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mon_len  = month_len(mon_reg, leap);

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        year_next  = year_reg;
        day_next   = day_reg;
        c100_next  = c100_reg;
        c400_next  = c400_reg;
        mon_next   = mon_reg;
        case (phase_reg)
            CAL_IDLE: begin
                if (req.start) begin
                    year_next  = req.year;
                    day_next   = req.days;
                    c100_next  = EPOCH_MOD_100;
                    c400_next  = EPOCH_MOD_400;
                    mon_next   = '0;
                    phase_next = CAL_YEAR;
                end
            end
            CAL_YEAR: begin
                if (day_reg < {9'd0, year_len}) begin
                    phase_next = CAL_MONTH;
                end else begin
                    day_next  = day_reg - {9'd0, year_len};
                    year_next = year_reg + 19'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end
            CAL_MONTH: begin
                if (mon_reg == LAST_MONTH || day_reg < {13'd0, mon_len}) begin
                    done_next  = 1'b1;
                    phase_next = CAL_IDLE;
                end else begin
                    day_next = day_reg - {13'd0, mon_len};
                    mon_next = mon_reg + 4'd1;
                end
            end
            default: phase_next = CAL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= CAL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        year_reg <= year_next;
        day_reg  <= day_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        mon_reg  <= mon_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.year  = year_reg;
    assign rsp.month = mon_reg + 4'd1;
    assign rsp.day   = day_reg[4:0] + 5'd1;

endmodule

>>> hdl/microsecond_tick_to_calendar.sv
// Converts a signed count of microseconds since 1970-01-01 into Gregorian
// calendar fields. An item enters on s_valid and s_ready; its sign selects
// local kind and its magnitude is the time. The result leaves on m_valid and
// m_ready as year, month, day of month, hour, minute, second, millisecond,
// weekday (0 is Sunday) and the local flag.
// The block works on one item at a time and holds s_ready low from the
// accepted item until its result is taken. A shared divider does seven
// divisions by constants, one quotient byte at a time through a
// reciprocal product. A year-by-year walk inside a 400-year era then
// finds the year, and a month walk finds the month and day; a new item
// is accepted only after the previous result has been taken.
// A result waits in its output registers while m_ready is low, and the
// next item is accepted in the cycle after it is taken.
// Reset is synchronous and active low; it returns the block to idle and
// drops any item in progress.
module microsecond_tick_to_calendar
    import mtc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_signed_tick,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [18:0]        m_year,
    output logic [3:0]         m_month,
    output logic [4:0]         m_day_of_month,
    output logic [4:0]         m_hour,
    output logic [5:0]         m_minute,
    output logic [5:0]         m_second,
    output logic [9:0]         m_millisecond,
    output logic [2:0]         m_weekday,
    output logic               m_is_local
);

    top_state_t             state_reg, state_next;
    div_sel_t               sel_reg, sel_next;
    logic [TickWidth-1:0]   t_reg, t_next;
    logic                   neg_reg, neg_next;
    logic [9:0]             ms_reg, ms_next;
    logic [5:0]             sec_reg, sec_next;
    logic [5:0]             min_reg, min_next;
    logic [4:0]             hr_reg, hr_next;
    logic [2:0]             wday_reg, wday_next;
    logic [EraWidth-1:0]    era_reg, era_next;
    logic [EraDayWidth-1:0] eday_reg, eday_next;
    logic [YearWidth-1:0]   ybase_reg, ybase_next;
    logic [YearWidth-1:0]   year_reg, year_next;
    logic [3:0]             month_reg, month_next;
    logic [4:0]             dom_reg, dom_next;

    logic [TickWidth-1:0]   raw;
    logic [TickWidth-1:0]   mag;
    logic [YearWidth-1:0]   era_years;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    cal_req_t               cal_req;
    cal_rsp_t               cal_rsp;

    assign raw       = s_signed_tick;
    assign mag       = raw[63] ? (~raw + 64'd1) : raw;
    assign era_years = YearWidth'(era_reg) * YearWidth'(YEARS_PER_ERA);

    assign div_req.start    = state_reg == ST_DIV_START;
    assign div_req.dividend = (sel_reg == DIV_WDAY) ? t_reg + EPOCH_WEEKDAY : t_reg;
    assign div_req.sel      = sel_reg;
    assign div_req.steps    = div_steps(sel_reg);

    assign cal_req.start = state_reg == ST_CAL_START;
    assign cal_req.year  = ybase_reg;
    assign cal_req.days  = eday_reg;

    mtc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    mtc_calendar u_calendar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cal_req),
        .rsp     (cal_rsp)
    );

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        t_next     = t_reg;
        neg_next   = neg_reg;
        ms_next    = ms_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        wday_next  = wday_reg;
        era_next   = era_reg;
        eday_next  = eday_reg;
        ybase_next = ybase_reg;
        year_next  = year_reg;
        month_next = month_reg;
        dom_next   = dom_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    t_next     = mag;
                    neg_next   = raw[63];
                    sel_next   = DIV_US;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_DIV_START;
                    case (sel_reg)
                        DIV_US: begin
                            t_next   = div_rsp.quotient;
                            sel_next = DIV_MS;
                        end
                        DIV_MS: begin
                            t_next   = div_rsp.quotient;
                            ms_next  = div_rsp.remainder[9:0];
                            sel_next = DIV_SEC;
                        end
                        DIV_SEC: begin
                            t_next   = div_rsp.quotient;
                            sec_next = div_rsp.remainder[5:0];
                            sel_next = DIV_MIN;
                        end
                        DIV_MIN: begin
                            t_next   = div_rsp.quotient;
                            min_next = div_rsp.remainder[5:0];
                            sel_next = DIV_HOUR;
                        end
                        DIV_HOUR: begin
                            t_next   = div_rsp.quotient;
                            hr_next  = div_rsp.remainder[4:0];
                            sel_next = DIV_WDAY;
                        end
                        DIV_WDAY: begin
                            wday_next = div_rsp.remainder[2:0];
                            sel_next  = DIV_ERA;
                        end
                        DIV_ERA: begin
                            era_next   = div_rsp.quotient[EraWidth-1:0];
                            eday_next  = div_rsp.remainder;
                            state_next = ST_YEAR_BASE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_YEAR_BASE: begin
                ybase_next = EPOCH_YEAR + era_years;
                state_next = ST_CAL_START;
            end
            ST_CAL_START: state_next = ST_CAL_WAIT;
            ST_CAL_WAIT: begin
                if (cal_rsp.done) begin
                    year_next  = cal_rsp.year;
                    month_next = cal_rsp.month;
                    dom_next   = cal_rsp.day;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_US;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg     <= t_next;
        neg_reg   <= neg_next;
        ms_reg    <= ms_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hr_reg    <= hr_next;
        wday_reg  <= wday_next;
        era_reg   <= era_next;
        eday_reg  <= eday_next;
        ybase_reg <= ybase_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        dom_reg   <= dom_next;
    end

    assign s_ready        = state_reg == ST_IDLE;
    assign m_valid        = state_reg == ST_OUT;
    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day_of_month = dom_reg;
    assign m_hour         = hr_reg;
    assign m_minute       = min_reg;
    assign m_second       = sec_reg;
    assign m_millisecond  = ms_reg;
    assign m_weekday      = wday_reg;
    assign m_is_local     = neg_reg;

endmodule

>>> hdl/mtc_checker.sv
`include "microsecond_tick_to_calendar_macros.svh"

module mtc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [18:0]        m_year,
    input logic [3:0]         m_month,
    input logic [4:0]         m_day_of_month,
    input logic [4:0]         m_hour,
    input logic [5:0]         m_minute,
    input logic [5:0]         m_second,
    input logic [9:0]         m_millisecond,
    input logic [2:0]         m_weekday,
    input logic               m_is_local
);

    `MTC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_year) && $stable(m_day_of_month) && $stable(m_is_local),
        "result item changed while stalled")

    `MTC_ASSERT_SAME(a_one_item, aclk, aresetn, s_ready, !m_valid,
        "input ready while a result item is pending")

    `MTC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
        "block ready again right after accepting an item")

    `MTC_ASSERT_SAME(a_date_range, aclk, aresetn, m_valid,
        m_month >= 4'd1 && m_month <= 4'd12 && m_day_of_month != 5'd0 && m_year >= 19'd1970,
        "calendar date field out of range")

    `MTC_ASSERT_SAME(a_time_range, aclk, aresetn, m_valid,
        m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59
            && m_millisecond <= 10'd999 && m_weekday <= 3'd6,
        "time of day field out of range")

endmodule

bind microsecond_tick_to_calendar mtc_checker u_mtc_checker (.*);

>>> tb/microsecond_tick_to_calendar_tb.sv
`timescale 1ns / 1ps

module microsecond_tick_to_calendar_tb;

    localparam longint unsigned US_PER_DAY = 64'd86400000000;
    localparam int unsigned     RANDOM_ITEMS = 1325;
    localparam int unsigned     CYCLE_LIMIT = 5000000;
    localparam int unsigned     SETTLE_CYCLES = 800;

    typedef struct packed {
        logic [18:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic [2:0]  weekday;
        logic        is_local;
    } calendar_t;

    class calendar_scoreboard;
        calendar_t   awaited_dates[$];
        int unsigned mismatches = 0;

        static function bit leap_year(longint unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_length(int unsigned month, bit leap);
            case (month)
                2:           return leap ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function calendar_t date_of_tick(logic [63:0] raw);
            calendar_t       d;
            logic [63:0]     mag;
            longint unsigned t;
            longint unsigned days;
            longint unsigned year;
            int unsigned     m;
            d.is_local = raw[63];
            mag = raw[63] ? 64'd0 - raw : raw;
            t = mag / 1000;
            d.millisecond = 10'(t % 1000);
            t = t / 1000;
            d.second = 6'(t % 60);
            t = t / 60;
            d.minute = 6'(t % 60);
            t = t / 60;
            d.hour = 5'(t % 24);
            days = t / 24;
            d.weekday = 3'((days + 4) % 7);
            year = 1970 + 400 * (days / 146097);
            days = days % 146097;
            while (days >= (leap_year(year) ? 366 : 365)) begin
                days = days - (leap_year(year) ? 366 : 365);
                year = year + 1;
            end
            m = 1;
            while (m < 12 && days >= month_length(m, leap_year(year))) begin
                days = days - month_length(m, leap_year(year));
                m = m + 1;
            end
            d.year = 19'(year);
            d.month = 4'(m);
            d.day_of_month = 5'(days + 1);
            return d;
        endfunction

        function void note_tick(logic [63:0] tick);
            awaited_dates.push_back(date_of_tick(tick));
        endfunction

        function void check_date(calendar_t got);
            calendar_t want;
            if (awaited_dates.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
                return;
            end
            want = awaited_dates.pop_front();
            if (got.year !== want.year) begin
                $error("year: expected %0d, actual %0d", want.year, got.year);
                mismatches++;
            end
            if (got.month !== want.month) begin
                $error("month: expected %0d, actual %0d", want.month, got.month);
                mismatches++;
            end
            if (got.day_of_month !== want.day_of_month) begin
                $error("day_of_month: expected %0d, actual %0d",
                       want.day_of_month, got.day_of_month);
                mismatches++;
            end
            if (got.hour !== want.hour) begin
                $error("hour: expected %0d, actual %0d", want.hour, got.hour);
                mismatches++;
            end
            if (got.minute !== want.minute) begin
                $error("minute: expected %0d, actual %0d", want.minute, got.minute);
                mismatches++;
            end
            if (got.second !== want.second) begin
                $error("second: expected %0d, actual %0d", want.second, got.second);
                mismatches++;
            end
            if (got.millisecond !== want.millisecond) begin
                $error("millisecond: expected %0d, actual %0d",
                       want.millisecond, got.millisecond);
                mismatches++;
            end
            if (got.weekday !== want.weekday) begin
                $error("weekday: expected %0d, actual %0d", want.weekday, got.weekday);
                mismatches++;
            end
            if (got.is_local !== want.is_local) begin
                $error("is_local: expected %0d, actual %0d", want.is_local, got.is_local);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [63:0] s_signed_tick;
    logic               m_valid;
    logic               m_ready;
    logic [18:0]        m_year;
    logic [3:0]         m_month;
    logic [4:0]         m_day_of_month;
    logic [4:0]         m_hour;
    logic [5:0]         m_minute;
    logic [5:0]         m_second;
    logic [9:0]         m_millisecond;
    logic [2:0]         m_weekday;
    logic               m_is_local;

    calendar_scoreboard sb;
    bit                 sender_burst = 1'b0;
    bit                 receiver_burst = 1'b0;
    int unsigned        cycles = 0;

    microsecond_tick_to_calendar uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_signed_tick  (s_signed_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_millisecond  (m_millisecond),
        .m_weekday      (m_weekday),
        .m_is_local     (m_is_local)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned idle_cycles(bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Builds a tick from a calendar date and a time of day in microseconds.
    function automatic logic signed [63:0] tick_at(int unsigned year, int unsigned month,
                                                   int unsigned day,
                                                   longint unsigned us_of_day,
                                                   bit local_kind);
        longint unsigned days;
        longint unsigned y1;
        logic [63:0]     mag;
        y1 = year - 1;
        days = 365 * longint'(year - 1970) + (y1 / 4 - y1 / 100 + y1 / 400)
               - (1969 / 4 - 1969 / 100 + 1969 / 400);
        for (int unsigned m = 1; m < month; m++)
            days += calendar_scoreboard::month_length(m,
                        calendar_scoreboard::leap_year(year));
        days += day - 1;
        mag = days * US_PER_DAY + us_of_day;
        return local_kind ? 64'd0 - mag : mag;
    endfunction

    task automatic send_tick(input logic signed [63:0] tick);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0)
            sender_burst = !sender_burst;
        gap = idle_cycles(sender_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_signed_tick <= tick;
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.awaited_dates.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_tick(s_signed_tick);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_date('{m_year, m_month, m_day_of_month, m_hour, m_minute,
                            m_second, m_millisecond, m_weekday, m_is_local});
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                receiver_burst = !receiver_burst;
            gap = idle_cycles(receiver_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready))
                @(posedge aclk);
        end
    end

    initial begin
        logic [63:0]     val;
        int unsigned     sel;
        int unsigned     y;
        int unsigned     mo;
        int unsigned     dy;
        longint unsigned tod;
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_signed_tick <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_tick(64'sd0);
        send_tick(64'sd999);
        send_tick(64'sd1000);
        send_tick(US_PER_DAY - 1);
        send_tick(US_PER_DAY);
        send_tick(-64'sd1);
        send_tick(64'sh7FFF_FFFF_FFFF_FFFF);
        send_tick(64'sh8000_0000_0000_0000);
        send_tick(64'sh8000_0000_0000_0001);
        send_tick(tick_at(2000, 2, 29, 0, 1'b1));
        send_tick(tick_at(2100, 2, 28, US_PER_DAY - 1, 1'b0));
        send_tick(tick_at(2100, 3, 1, 0, 1'b0));
        send_tick(tick_at(2400, 12, 31, US_PER_DAY - 1, 1'b1));
        for (int unsigned m = 1; m <= 12; m++)
            send_tick(tick_at(1972, m, calendar_scoreboard::month_length(m, 1'b1),
                              {$urandom, $urandom} % US_PER_DAY, m[0]));
        drain_results();

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                val = {$urandom, $urandom};
            end else if (sel < 45) begin
                val = {$urandom, $urandom} >> $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    val = 64'd0 - val;
            end else begin
                case ($urandom_range(0, 3))
                    0:       y = 1970 + $urandom_range(0, 130);
                    1:       y = 100 * $urandom_range(20, 2942) - 1 + $urandom_range(0, 2);
                    2:       y = 400 * $urandom_range(5, 735) - $urandom_range(0, 1);
                    default: y = $urandom_range(1970, 294246);
                endcase
                mo = $urandom_range(1, 12);
                case ($urandom_range(0, 2))
                    0:       dy = 1;
                    1:       dy = calendar_scoreboard::month_length(mo,
                                      calendar_scoreboard::leap_year(y));
                    default: dy = $urandom_range(1, calendar_scoreboard::month_length(mo,
                                      calendar_scoreboard::leap_year(y)));
                endcase
                case ($urandom_range(0, 2))
                    0:       tod = $urandom_range(0, 999);
                    1:       tod = US_PER_DAY - 1 - $urandom_range(0, 999);
                    default: tod = {$urandom, $urandom} % US_PER_DAY;
                endcase
                val = tick_at(y, mo, dy, tod, $urandom_range(0, 1));
            end
            send_tick(val);
            if (i % 300 == 299)
                drain_results();
        end
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_dates.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
